@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ sv/tri2d_pkg.sv @@
package tri2d_pkg;

  // Fixed field widths.
  localparam int COORD_BITS = 24;
  localparam int RANGE_BITS = COORD_BITS - 1;
  localparam int OUT_BITS   = 32;
  localparam int IDX_BITS   = 3;

  // Datapath widths.
  localparam int DW   = COORD_BITS + 1;   // anchor difference
  localparam int SQW  = 2 * DW;           // product of two differences
  localparam int RSQW = 2 * RANGE_BITS;   // squared range
  localparam int KW   = SQW + 2;          // range/spacing term
  localparam int CW   = SQW + 1;          // cross product
  localparam int KLW  = KW / 2;           // low split of a K term
  localparam int KHW  = KW - KLW;         // high split of a K term
  localparam int PLW  = KLW + 1 + DW;
  localparam int PHW  = KHW + DW;
  localparam int PW   = KW + DW;          // full K times difference
  localparam int NSW  = PW + 1;           // signed numerator
  localparam int NW   = PW;               // unsigned dividend, also quotient
  localparam int RW   = CW + 1;           // divisor and partial remainder
  localparam int QSW  = NW + 1;           // signed quotient
  localparam int SW   = QSW + 1;          // quotient plus anchor

  localparam int FRONT_STAGES = 8;
  localparam int BACK_STAGES  = 2;
  localparam int LATENCY      = FRONT_STAGES + NW + BACK_STAGES;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_ANCHOR1_X = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_ANCHOR1_Y = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ANCHOR2_X = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_ANCHOR2_Y = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_ANCHOR3_X = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_ANCHOR3_Y = 3'd5;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [RANGE_BITS-1:0]        range_t;
  typedef logic signed [DW-1:0]         diff_t;
  typedef logic signed [SQW-1:0]        sq_t;
  typedef logic [RSQW-1:0]              rsq_t;
  typedef logic signed [KW-1:0]         k_t;
  typedef logic signed [CW-1:0]         c_t;
  typedef logic [CW-1:0]                cabs_t;
  typedef logic signed [PLW-1:0]        prodl_t;
  typedef logic signed [PHW-1:0]        prodh_t;
  typedef logic signed [PW-1:0]         full_t;
  typedef logic signed [NSW-1:0]        num_t;
  typedef logic [NW-1:0]                dvd_t;
  typedef logic [RW-1:0]                rem_t;

  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t ax;
    diff_t ay;
  } geo_t;

  typedef struct packed {
    coord_t p1x;
    coord_t p1y;
  } orig_t;

  // One division lane: partial remainder and dividend/quotient shift word.
  typedef struct packed {
    rem_t rem;
    dvd_t num;
  } lane_t;

  // Data that rides along the divider chain.
  typedef struct packed {
    rem_t  div;
    logic  neg_x;
    logic  neg_y;
    logic  invalid;
    orig_t orig;
  } side_t;

endpackage

@@ sv/tri2d_div_cell.sv @@
module tri2d_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  tri2d_pkg::lane_t   in_x,
  input  tri2d_pkg::lane_t   in_y,
  input  tri2d_pkg::side_t   in_side,
  output logic               out_vld,
  output tri2d_pkg::lane_t   out_x,
  output tri2d_pkg::lane_t   out_y,
  output tri2d_pkg::side_t   out_side
);

  logic             vld_r;
  tri2d_pkg::lane_t x_r, y_r, x_nxt, y_nxt;
  tri2d_pkg::side_t side_r;
  tri2d_pkg::rem_t  shx, shy;
  logic             gex, gey;

  // One restoring step for each lane against the shared divisor.
  always_comb begin
    shx = {in_x.rem[tri2d_pkg::RW-2:0], in_x.num[tri2d_pkg::NW-1]};
    shy = {in_y.rem[tri2d_pkg::RW-2:0], in_y.num[tri2d_pkg::NW-1]};
    gex = (shx >= in_side.div);
    gey = (shy >= in_side.div);
    x_nxt.rem = gex ? (shx - in_side.div) : shx;
    y_nxt.rem = gey ? (shy - in_side.div) : shy;
    x_nxt.num = {in_x.num[tri2d_pkg::NW-2:0], gex};
    y_nxt.num = {in_y.num[tri2d_pkg::NW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_side = side_r;

endmodule

@@ sv/trilateration_2d_unit.sv @@
// Planar trilateration from three ranges to three anchors held in
// configuration. A range triple is taken on every clock at which start is
// high (busy never rises). Its position passes eight front stages for the
// anchor differences, squares, cross products, numerators, magnitudes and
// rounding bias, a chain of 77 divider cells that each settle one quotient
// bit for x and y, and two stages for sign, anchor offset and saturation,
// and then appears on the out_ ports with out_valid for one cycle. The
// receiver cannot stall the block, so every result must be taken in the
// cycle it is shown. Anchor writes are for idle periods only.
module trilateration_2d_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]        in_range1,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]        in_range2,
  input  logic [tri2d_pkg::RANGE_BITS-1:0]        in_range3,
  output logic                                    out_valid,
  output logic signed [tri2d_pkg::OUT_BITS-1:0]   out_pos_x,
  output logic signed [tri2d_pkg::OUT_BITS-1:0]   out_pos_y,
  output logic                                    out_geometry_invalid,
  output logic                                    out_overflow,
  input  logic                                    cfg_we,
  input  logic [tri2d_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [tri2d_pkg::COORD_BITS-1:0]        cfg_wdata
);

  localparam int CB = tri2d_pkg::COORD_BITS;
  localparam int FS = tri2d_pkg::FRONT_STAGES;
  localparam int NW = tri2d_pkg::NW;

  tri2d_pkg::coord_t a1x_r, a1y_r, a2x_r, a2y_r, a3x_r, a3y_r;
  logic              accept;
  logic [FS-1:0]     fv_r;

  // Anchor registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1x_r <= '0;
      a1y_r <= '0;
      a2x_r <= '0;
      a2y_r <= '0;
      a3x_r <= '0;
      a3y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tri2d_pkg::REG_ANCHOR1_X: a1x_r <= cfg_wdata;
        tri2d_pkg::REG_ANCHOR1_Y: a1y_r <= cfg_wdata;
        tri2d_pkg::REG_ANCHOR2_X: a2x_r <= cfg_wdata;
        tri2d_pkg::REG_ANCHOR2_Y: a2y_r <= cfg_wdata;
        tri2d_pkg::REG_ANCHOR3_X: a3x_r <= cfg_wdata;
        tri2d_pkg::REG_ANCHOR3_Y: a3y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[FS-2:0], accept};
    end
  end

  // Stage 1: anchor differences relative to anchor 1 and the ranges.
  tri2d_pkg::geo_t   geo1_r, geo1_nxt, geo2_r, geo3_r;
  tri2d_pkg::orig_t  org1_r, org2_r, org3_r, org4_r, org5_r, org6_r, org7_r;
  tri2d_pkg::range_t r1_r, r2_r, r3_r;

  always_comb begin
    geo1_nxt.dx = {a2x_r[CB-1], a2x_r} - {a1x_r[CB-1], a1x_r};
    geo1_nxt.dy = {a2y_r[CB-1], a2y_r} - {a1y_r[CB-1], a1y_r};
    geo1_nxt.ax = {a3x_r[CB-1], a3x_r} - {a1x_r[CB-1], a1x_r};
    geo1_nxt.ay = {a3y_r[CB-1], a3y_r} - {a1y_r[CB-1], a1y_r};
  end

  always_ff @(posedge clk) begin
    geo1_r     <= geo1_nxt;
    org1_r.p1x <= a1x_r;
    org1_r.p1y <= a1y_r;
    r1_r       <= in_range1;
    r2_r       <= in_range2;
    r3_r       <= in_range3;
  end

  // Stage 2: squares and the two cross terms.
  tri2d_pkg::rsq_t r1s_r, r2s_r, r3s_r, r1s_nxt, r2s_nxt, r3s_nxt;
  tri2d_pkg::sq_t  dx2_r, dy2_r, ax2_r, ay2_r, dxay_r, dyax_r;
  tri2d_pkg::sq_t  dx2_nxt, dy2_nxt, ax2_nxt, ay2_nxt, dxay_nxt, dyax_nxt;

  always_comb begin
    r1s_nxt  = r1_r * r1_r;
    r2s_nxt  = r2_r * r2_r;
    r3s_nxt  = r3_r * r3_r;
    dx2_nxt  = geo1_r.dx * geo1_r.dx;
    dy2_nxt  = geo1_r.dy * geo1_r.dy;
    ax2_nxt  = geo1_r.ax * geo1_r.ax;
    ay2_nxt  = geo1_r.ay * geo1_r.ay;
    dxay_nxt = geo1_r.dx * geo1_r.ay;
    dyax_nxt = geo1_r.dy * geo1_r.ax;
  end

  always_ff @(posedge clk) begin
    r1s_r  <= r1s_nxt;
    r2s_r  <= r2s_nxt;
    r3s_r  <= r3s_nxt;
    dx2_r  <= dx2_nxt;
    dy2_r  <= dy2_nxt;
    ax2_r  <= ax2_nxt;
    ay2_r  <= ay2_nxt;
    dxay_r <= dxay_nxt;
    dyax_r <= dyax_nxt;
    geo2_r <= geo1_r;
    org2_r <= org1_r;
  end

  // Stage 3: the K terms and the cross product C.
  tri2d_pkg::k_t k1_r, k3_r, k1_nxt, k3_nxt;
  tri2d_pkg::c_t c3_r, c3_nxt, c4_r, c5_r, c6_r;

  always_comb begin
    k1_nxt = tri2d_pkg::KW'(dx2_r) + tri2d_pkg::KW'(dy2_r)
           + tri2d_pkg::KW'(r1s_r) - tri2d_pkg::KW'(r2s_r);
    k3_nxt = tri2d_pkg::KW'(ax2_r) + tri2d_pkg::KW'(ay2_r)
           + tri2d_pkg::KW'(r1s_r) - tri2d_pkg::KW'(r3s_r);
    c3_nxt = tri2d_pkg::CW'(dxay_r) - tri2d_pkg::CW'(dyax_r);
  end

  always_ff @(posedge clk) begin
    k1_r   <= k1_nxt;
    k3_r   <= k3_nxt;
    c3_r   <= c3_nxt;
    geo3_r <= geo2_r;
    org3_r <= org2_r;
  end

  // Stage 4: split products of K with the anchor differences.
  // Terms in order: K1*ay, K3*dy, K3*dx, K1*ax.
  tri2d_pkg::prodl_t pl_r [4];
  tri2d_pkg::prodh_t ph_r [4];
  tri2d_pkg::prodl_t pl_nxt [4];
  tri2d_pkg::prodh_t ph_nxt [4];
  tri2d_pkg::k_t     kop [4];
  tri2d_pkg::diff_t  dop [4];
  logic signed [tri2d_pkg::KLW:0]   klo [4];
  logic signed [tri2d_pkg::KHW-1:0] khi [4];

  always_comb begin
    kop[0] = k1_r;  dop[0] = geo3_r.ay;
    kop[1] = k3_r;  dop[1] = geo3_r.dy;
    kop[2] = k3_r;  dop[2] = geo3_r.dx;
    kop[3] = k1_r;  dop[3] = geo3_r.ax;
    for (int i = 0; i < 4; i++) begin
      klo[i]    = {1'b0, kop[i][tri2d_pkg::KLW-1:0]};
      khi[i]    = kop[i][tri2d_pkg::KW-1:tri2d_pkg::KLW];
      pl_nxt[i] = klo[i] * dop[i];
      ph_nxt[i] = khi[i] * dop[i];
    end
  end

  always_ff @(posedge clk) begin
    pl_r   <= pl_nxt;
    ph_r   <= ph_nxt;
    c4_r   <= c3_r;
    org4_r <= org3_r;
  end

  // Stage 5: recombine the split products.
  tri2d_pkg::full_t fp_r [4];
  tri2d_pkg::full_t fp_nxt [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fp_nxt[i] = (tri2d_pkg::PW'(ph_r[i]) <<< tri2d_pkg::KLW) + tri2d_pkg::PW'(pl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    fp_r   <= fp_nxt;
    c5_r   <= c4_r;
    org5_r <= org4_r;
  end

  // Stage 6: numerators of x and y.
  tri2d_pkg::num_t nx_r, ny_r, nx_nxt, ny_nxt;

  always_comb begin
    nx_nxt = tri2d_pkg::NSW'(fp_r[0]) - tri2d_pkg::NSW'(fp_r[1]);
    ny_nxt = tri2d_pkg::NSW'(fp_r[2]) - tri2d_pkg::NSW'(fp_r[3]);
  end

  always_ff @(posedge clk) begin
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    c6_r   <= c5_r;
    org6_r <= org5_r;
  end

  // Stage 7: magnitudes and quotient signs.
  tri2d_pkg::dvd_t  anx_r, any_r, anx_nxt, any_nxt;
  tri2d_pkg::cabs_t ac_r, ac_nxt;
  logic             negx_r, negy_r, inv_r;
  tri2d_pkg::num_t  nxn, nyn;
  tri2d_pkg::c_t    cn;

  always_comb begin
    nxn     = -nx_r;
    nyn     = -ny_r;
    cn      = -c6_r;
    anx_nxt = nx_r[tri2d_pkg::NSW-1] ? NW'(nxn) : NW'(nx_r);
    any_nxt = ny_r[tri2d_pkg::NSW-1] ? NW'(nyn) : NW'(ny_r);
    ac_nxt  = c6_r[tri2d_pkg::CW-1] ? cn : c6_r;
  end

  always_ff @(posedge clk) begin
    anx_r  <= anx_nxt;
    any_r  <= any_nxt;
    ac_r   <= ac_nxt;
    negx_r <= nx_r[tri2d_pkg::NSW-1] ^ c6_r[tri2d_pkg::CW-1];
    negy_r <= ny_r[tri2d_pkg::NSW-1] ^ c6_r[tri2d_pkg::CW-1];
    inv_r  <= (c6_r == '0);
    org7_r <= org6_r;
  end

  // Stage 8: rounding bias in the dividend, doubled divisor.
  tri2d_pkg::lane_t ch_x [NW+1];
  tri2d_pkg::lane_t ch_y [NW+1];
  tri2d_pkg::side_t ch_s [NW+1];
  logic             ch_v [NW+1];
  tri2d_pkg::dvd_t  dvx_r, dvy_r;
  tri2d_pkg::side_t sd8_r, sd8_nxt;

  always_comb begin
    sd8_nxt.div     = {ac_r, 1'b0};
    sd8_nxt.neg_x   = negx_r;
    sd8_nxt.neg_y   = negy_r;
    sd8_nxt.invalid = inv_r;
    sd8_nxt.orig    = org7_r;
  end

  always_ff @(posedge clk) begin
    dvx_r  <= anx_r + NW'(ac_r);
    dvy_r  <= any_r + NW'(ac_r);
    sd8_r  <= sd8_nxt;
  end

  assign ch_v[0]     = fv_r[FS-1];
  assign ch_x[0].rem = '0;
  assign ch_x[0].num = dvx_r;
  assign ch_y[0].rem = '0;
  assign ch_y[0].num = dvy_r;
  assign ch_s[0]     = sd8_r;

  // Divider chain: one quotient bit per cell.
  for (genvar g = 0; g < NW; g++) begin : g_cell
    tri2d_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (ch_v[g]),
      .in_x     (ch_x[g]),
      .in_y     (ch_y[g]),
      .in_side  (ch_s[g]),
      .out_vld  (ch_v[g+1]),
      .out_x    (ch_x[g+1]),
      .out_y    (ch_y[g+1]),
      .out_side (ch_s[g+1])
    );
  end

  // Back stage 1: apply the quotient signs.
  logic signed [tri2d_pkg::QSW-1:0] qx_r, qy_r, qx_nxt, qy_nxt, qxp, qyp;
  logic                             bv_r, binv_r;
  tri2d_pkg::orig_t                 borg_r;

  always_comb begin
    qxp    = {1'b0, ch_x[NW].num};
    qyp    = {1'b0, ch_y[NW].num};
    qx_nxt = ch_s[NW].neg_x ? -qxp : qxp;
    qy_nxt = ch_s[NW].neg_y ? -qyp : qyp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else begin
      bv_r <= ch_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    binv_r <= ch_s[NW].invalid;
    borg_r <= ch_s[NW].orig;
  end

  // Back stage 2: add anchor 1, saturate, and register the result.
  logic signed [tri2d_pkg::SW-1:0]       sx, sy;
  logic                                  fitx, fity;
  logic signed [tri2d_pkg::OUT_BITS-1:0] px_nxt, py_nxt;
  logic                                  ovf_nxt;

  always_comb begin
    sx   = tri2d_pkg::SW'(qx_r) + tri2d_pkg::SW'(borg_r.p1x);
    sy   = tri2d_pkg::SW'(qy_r) + tri2d_pkg::SW'(borg_r.p1y);
    fitx = (&sx[tri2d_pkg::SW-1:tri2d_pkg::OUT_BITS-1])
        || (~|sx[tri2d_pkg::SW-1:tri2d_pkg::OUT_BITS-1]);
    fity = (&sy[tri2d_pkg::SW-1:tri2d_pkg::OUT_BITS-1])
        || (~|sy[tri2d_pkg::SW-1:tri2d_pkg::OUT_BITS-1]);
    px_nxt  = fitx ? sx[tri2d_pkg::OUT_BITS-1:0]
            : (sx[tri2d_pkg::SW-1] ? tri2d_pkg::OUT_MIN : tri2d_pkg::OUT_MAX);
    py_nxt  = fity ? sy[tri2d_pkg::OUT_BITS-1:0]
            : (sy[tri2d_pkg::SW-1] ? tri2d_pkg::OUT_MIN : tri2d_pkg::OUT_MAX);
    ovf_nxt = !(fitx && fity);
    if (binv_r) begin
      px_nxt  = '0;
      py_nxt  = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= bv_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_x            <= px_nxt;
    out_pos_y            <= py_nxt;
    out_geometry_invalid <= binv_r;
    out_overflow         <= ovf_nxt;
  end

endmodule

@@ sv/tri2d_checker.sv @@
`include "assert_macros.svh"

module tri2d_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic signed [tri2d_pkg::OUT_BITS-1:0] out_pos_x,
  input logic signed [tri2d_pkg::OUT_BITS-1:0] out_pos_y,
  input logic                                  out_geometry_invalid,
  input logic                                  out_overflow
);

  // Every accepted transfer yields one result after the fixed latency.
  `ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##(tri2d_pkg::LATENCY) out_valid)

  // No result appears without a transfer that latency ago.
  `ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, tri2d_pkg::LATENCY))

  // Degenerate anchors give a zero position and no overflow.
  `ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && out_geometry_invalid, (out_pos_x == '0) && (out_pos_y == '0) && !out_overflow)

  // Overflow is only reported with a coordinate at a bound.
  `ASSERT_IMP(a_ovf_bound, clk, rst_n, out_valid && out_overflow, (out_pos_x == tri2d_pkg::OUT_MAX) || (out_pos_x == tri2d_pkg::OUT_MIN) || (out_pos_y == tri2d_pkg::OUT_MAX) || (out_pos_y == tri2d_pkg::OUT_MIN))

endmodule

bind trilateration_2d_unit tri2d_checker u_tri2d_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_pos_x            (out_pos_x),
  .out_pos_y            (out_pos_y),
  .out_geometry_invalid (out_geometry_invalid),
  .out_overflow         (out_overflow)
);
